// ===== rtl/dfe_pkg.sv =====
// dfe_pkg: shared types and constants of the delimited field extractor
// no dependencies; used by dfe_scan, dfe_result_buf and the top level
`default_nettype none

package dfe_pkg;

	// results one input transaction can cause, terminal included
	localparam int RESULT_CAP = 4;
	localparam int RES_CNT_W  = $clog2(RESULT_CAP + 1);
	localparam int RES_IDX_W  = $clog2(RESULT_CAP);

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int FIELD_W    = 16;
	localparam int DLEN_W     = 3;

	localparam logic [CFG_DATA_W-1:0] DELIM_BYTES_RST = 32'd10;
	localparam logic [DLEN_W-1:0]     DELIM_LEN_RST   = 3'd1;
	localparam logic [FIELD_W-1:0]    FIELD_IDX_RST   = 16'd0;

	localparam logic [7:0] TERM_BYTE = 8'h00;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DELIM_BYTES = 2'd0,
		CFG_DELIM_LEN   = 2'd1,
		CFG_FIELD_IDX   = 2'd2
	} cfg_reg_t;

	// group of results produced by one input transaction
	typedef struct packed {
		logic [RESULT_CAP-1:0][7:0] data;
		logic [RES_CNT_W-1:0]       count;
		logic                       term;
		logic                       found;
	} bundle_t;

endpackage

`default_nettype wire

// ===== rtl/delimited_field_extractor_top.sv =====
// delimited_field_extractor_top: selects one field of a delimited byte stream
// depends on dfe_pkg, dfe_scan and dfe_result_buf
//
// channel   signals                                 direction  notes
// cfg       cfg_we, cfg_addr, cfg_wdata             in         write only, no wait
// in        in_valid/in_ready, in_byte, in_last     in         one byte per transaction
// out       out_valid/out_ready, out_byte,          out        field bytes, then one
//           out_end, field_found                               terminal per text
//
// an input byte lands in the input register, is scanned in the next cycle and its results
// (zero to four) are written to the result register, which hands them out in order
// one byte per cycle is taken as long as each byte causes at most one result and out_ready
// stays high; a byte with several results holds the result register for one transaction each
// the input register refills in the same cycle the result register hands over its last result
// arst_n clears control and text state at once; no clearing pass is needed
`default_nettype none

module delimited_field_extractor_top #(
	parameter int MAX_DELIM_LEN = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration writes
	input  logic                             cfg_we,
	input  logic [dfe_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [dfe_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	// input stream
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       in_byte,
	input  logic                             in_last,
	// result stream
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       out_byte,
	output logic                             out_end,
	output logic                             field_found
);

	// held bytes: at most one less than the longest delimiter
	localparam int PD = (MAX_DELIM_LEN > 1) ? MAX_DELIM_LEN - 1 : 1;
	localparam int CW = (MAX_DELIM_LEN > 1) ? $clog2(MAX_DELIM_LEN) : 1;

	// configuration registers
	logic [dfe_pkg::CFG_DATA_W-1:0] delim_bytes_q;
	logic [dfe_pkg::DLEN_W-1:0]     delim_len_q;
	logic [dfe_pkg::FIELD_W-1:0]    field_idx_q;

	// input register
	logic                           vld_s1;
	logic [7:0]                     byte_s1;
	logic                           last_s1;

	// text state carried from byte to byte
	logic [PD-1:0][7:0]             pend_q;
	logic [CW-1:0]                  pend_cnt_q;
	logic [dfe_pkg::FIELD_W-1:0]    fields_q;
	logic                           has_q;

	// scan results
	dfe_pkg::bundle_t               bnd;
	logic [PD-1:0][7:0]             nxt_pend;
	logic [CW-1:0]                  nxt_cnt;
	logic [dfe_pkg::FIELD_W-1:0]    nxt_fields;
	logic                           nxt_has;

	logic                           buf_free;
	logic                           advance;

	// the scanned byte moves on once the result register can take its group
	assign advance  = vld_s1 && buf_free;
	assign in_ready = !vld_s1 || advance;

	// register writes; an index beyond the list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_bytes_q <= dfe_pkg::DELIM_BYTES_RST;
			delim_len_q   <= dfe_pkg::DELIM_LEN_RST;
			field_idx_q   <= dfe_pkg::FIELD_IDX_RST;
		end else if (cfg_we) begin
			unique case (dfe_pkg::cfg_reg_t'(cfg_addr))
				dfe_pkg::CFG_DELIM_BYTES: delim_bytes_q <= cfg_wdata;
				dfe_pkg::CFG_DELIM_LEN:   delim_len_q   <= cfg_wdata[dfe_pkg::DLEN_W-1:0];
				dfe_pkg::CFG_FIELD_IDX:   field_idx_q   <= cfg_wdata[dfe_pkg::FIELD_W-1:0];
				default: ;
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// text state advances with each scanned byte; the last byte returns it to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			pend_cnt_q <= '0;
			fields_q   <= '0;
			has_q      <= 1'b0;
		end else if (advance) begin
			pend_q     <= nxt_pend;
			pend_cnt_q <= nxt_cnt;
			fields_q   <= nxt_fields;
			has_q      <= nxt_has;
		end
	end

	// delimiter window compare, field counting and result selection
	dfe_scan #(
		.MAX_DELIM_LEN (MAX_DELIM_LEN)
	) u_scan (
		.pend        (pend_q),
		.pend_cnt    (pend_cnt_q),
		.in_byte     (byte_s1),
		.in_last     (last_s1),
		.delim_bytes (delim_bytes_q),
		.delim_len   (delim_len_q),
		.field_idx   (field_idx_q),
		.fields_done (fields_q),
		.has_bytes   (has_q),
		.bnd         (bnd),
		.nxt_pend    (nxt_pend),
		.nxt_cnt     (nxt_cnt),
		.nxt_fields  (nxt_fields),
		.nxt_has     (nxt_has)
	);

	// result register, one output transaction per cycle while out_ready is high
	dfe_result_buf u_res (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance),
		.bnd         (bnd),
		.free        (buf_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.out_end     (out_end),
		.field_found (field_found)
	);

endmodule

`default_nettype wire

// ===== rtl/dfe_scan.sv =====
// dfe_scan: window compare and field walk for one input byte
// depends on dfe_pkg; purely combinational, sits between the input and result registers
`default_nettype none

module dfe_scan #(
	parameter int MAX_DELIM_LEN = 4,
	localparam int PD = (MAX_DELIM_LEN > 1) ? MAX_DELIM_LEN - 1 : 1,
	localparam int CW = (MAX_DELIM_LEN > 1) ? $clog2(MAX_DELIM_LEN) : 1
) (
	input  logic [PD-1:0][7:0]                   pend,
	input  logic [CW-1:0]                        pend_cnt,
	input  logic [7:0]                           in_byte,
	input  logic                                 in_last,
	input  logic [dfe_pkg::CFG_DATA_W-1:0]       delim_bytes,
	input  logic [dfe_pkg::DLEN_W-1:0]           delim_len,
	input  logic [dfe_pkg::FIELD_W-1:0]          field_idx,
	input  logic [dfe_pkg::FIELD_W-1:0]          fields_done,
	input  logic                                 has_bytes,
	output dfe_pkg::bundle_t                     bnd,
	output logic [PD-1:0][7:0]                   nxt_pend,
	output logic [CW-1:0]                        nxt_cnt,
	output logic [dfe_pkg::FIELD_W-1:0]          nxt_fields,
	output logic                                 nxt_has
);

	localparam int NW = $clog2(MAX_DELIM_LEN + 1);
	localparam int SW = NW + 1;

	logic [MAX_DELIM_LEN-1:0][7:0]               win;
	logic [NW-1:0]                               n_w;
	logic [NW-1:0]                               len_w;
	logic [MAX_DELIM_LEN-1:0]                    full_m;
	logic [MAX_DELIM_LEN-1:0]                    part_m;
	logic [MAX_DELIM_LEN:0][dfe_pkg::FIELD_W-1:0] sat_f;
	logic [MAX_DELIM_LEN:0]                      eq_f;
	logic [MAX_DELIM_LEN:0]                      gt_f;

	function automatic logic [7:0] delim_at(input logic [31:0] bytes, input int k);
		delim_at = (k < 4) ? bytes[8*(k % 4) +: 8] : 8'h00;
	endfunction

	// held bytes, then the new byte
	always_comb begin
		win = '0;
		for (int j = 0; j < PD; j++) begin
			if (NW'(j) < NW'(pend_cnt))
				win[j] = pend[j];
		end
		for (int j = 0; j < MAX_DELIM_LEN; j++) begin
			if (NW'(j) == NW'(pend_cnt))
				win[j] = in_byte;
		end
		n_w = NW'(pend_cnt) + NW'(1);
	end

	// zero acts as one, too long clamps to the maximum
	always_comb begin
		if (int'(delim_len) > MAX_DELIM_LEN)
			len_w = NW'(MAX_DELIM_LEN);
		else if (delim_len == '0)
			len_w = NW'(1);
		else
			len_w = NW'(delim_len);
	end

	// delimiter compare at every window position
	always_comb begin
		logic ok;
		for (int p = 0; p < MAX_DELIM_LEN; p++) begin
			ok = 1'b1;
			for (int k = 0; k < MAX_DELIM_LEN - p; k++) begin
				if ((NW'(k) < len_w) && (NW'(p + k) < n_w) &&
				    (win[p + k] != delim_at(delim_bytes, k)))
					ok = 1'b0;
			end
			full_m[p] = ok && (NW'(p) < n_w) && ((n_w - NW'(p)) >= len_w);
			part_m[p] = ok && (NW'(p) < n_w) && ((n_w - NW'(p)) < len_w);
		end
	end

	// saturated field count for each number of delimiters seen in this step
	always_comb begin
		logic [dfe_pkg::FIELD_W:0] sum_v;
		for (int j = 0; j <= MAX_DELIM_LEN; j++) begin
			sum_v    = {1'b0, fields_done} + (dfe_pkg::FIELD_W + 1)'(j);
			sat_f[j] = sum_v[dfe_pkg::FIELD_W] ? '1 : sum_v[dfe_pkg::FIELD_W-1:0];
			eq_f[j]  = (sat_f[j] == field_idx);
			gt_f[j]  = (sat_f[j] > field_idx);
		end
	end

	// walk the window oldest byte first
	always_comb begin
		logic                          active;
		logic [NW-1:0]                 skip;
		logic [NW-1:0]                 kc;
		logic [NW-1:0]                 hold;
		logic                          hasv;
		logic [dfe_pkg::RES_CNT_W-1:0] outn;
		logic [dfe_pkg::RES_CNT_W-1:0] cap;
		logic [SW-1:0]                 src;

		bnd    = '0;
		active = 1'b1;
		skip   = '0;
		kc     = '0;
		hold   = n_w;
		hasv   = has_bytes;
		outn   = '0;
		cap    = in_last ? dfe_pkg::RES_CNT_W'(dfe_pkg::RESULT_CAP - 1)
		                 : dfe_pkg::RES_CNT_W'(dfe_pkg::RESULT_CAP);

		for (int p = 0; p < MAX_DELIM_LEN; p++) begin
			if (active && (NW'(p) < n_w)) begin
				if (skip != '0) begin
					skip = skip - NW'(1);
				end else if (full_m[p]) begin
					if (hasv)
						kc = kc + NW'(1);
					hasv = 1'b0;
					skip = len_w - NW'(1);
				end else if (part_m[p] && !in_last) begin
					active = 1'b0;
					hold   = NW'(p);
				end else begin
					// text byte; on the last byte a partial match is released as text
					if (eq_f[kc] && (outn < cap)) begin
						bnd.data[outn[dfe_pkg::RES_IDX_W-1:0]] = win[p];
						outn = outn + dfe_pkg::RES_CNT_W'(1);
					end
					hasv = 1'b1;
				end
			end
		end

		nxt_pend = '0;
		for (int i = 0; i < PD; i++) begin
			src = SW'(hold) + SW'(i);
			for (int j = 0; j < MAX_DELIM_LEN; j++) begin
				if (src == SW'(j))
					nxt_pend[i] = win[j];
			end
		end

		if (in_last) begin
			bnd.count  = outn + dfe_pkg::RES_CNT_W'(1);
			bnd.term   = 1'b1;
			bnd.found  = gt_f[kc] || (eq_f[kc] && hasv);
			nxt_pend   = '0;
			nxt_cnt    = '0;
			nxt_fields = '0;
			nxt_has    = 1'b0;
		end else begin
			bnd.count  = outn;
			bnd.term   = 1'b0;
			bnd.found  = 1'b0;
			nxt_cnt    = CW'(n_w - hold);
			nxt_fields = sat_f[kc];
			nxt_has    = hasv;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dfe_result_buf.sv =====
// dfe_result_buf: result register holding one group of results, drained one per cycle while out_ready is high
// depends on dfe_pkg
`default_nettype none

module dfe_result_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  dfe_pkg::bundle_t bnd,
	output logic             free,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             out_end,
	output logic             field_found
);

	logic [dfe_pkg::RESULT_CAP-1:0][7:0] data_s2;
	logic                                term_s2;
	logic                                found_s2;
	logic [dfe_pkg::RES_CNT_W-1:0]       cnt_s2;
	logic [dfe_pkg::RES_CNT_W-1:0]       rd_q;
	logic                                last_entry;

	assign out_valid  = (rd_q < cnt_s2);
	assign last_entry = ((rd_q + dfe_pkg::RES_CNT_W'(1)) == cnt_s2);
	assign free       = !out_valid || (out_ready && last_entry);

	assign out_end     = out_valid && term_s2 && last_entry;
	assign out_byte    = out_end ? dfe_pkg::TERM_BYTE
	                             : data_s2[rd_q[dfe_pkg::RES_IDX_W-1:0]];
	assign field_found = out_end && found_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
			rd_q   <= '0;
		end else if (load) begin
			cnt_s2 <= bnd.count;
			rd_q   <= '0;
		end else if (out_valid && out_ready) begin
			rd_q <= rd_q + dfe_pkg::RES_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s2  <= bnd.data;
			term_s2  <= bnd.term;
			found_s2 <= bnd.found;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dfe_checker.sv =====
// dfe_checker: port-level checks of the delimited field extractor
// depends on delimited_field_extractor_top's ports; attached by the bind below
`default_nettype none

module dfe_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_we,
	input logic [dfe_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input logic [dfe_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic [7:0]                     in_byte,
	input logic                           in_last,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [7:0]                     out_byte,
	input logic                           out_end,
	input logic                           field_found
);

	// texts whose last byte was taken but whose terminal is not yet delivered
	logic [2:0] open_q;
	logic       in_fire;
	logic       out_fire;

	assign in_fire  = in_valid && in_ready && in_last;
	assign out_fire = out_valid && out_ready && out_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (in_fire && !out_fire) begin
			open_q <= open_q + 3'd1;
		end else if (out_fire && !in_fire) begin
			open_q <= open_q - 3'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
		$stable(out_end) && $stable(field_found))
		else $error("result changed while stalled");

	a_term_owed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_end |-> open_q != 3'd0)
		else $error("terminal without a last input byte");

	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= 3'd2)
		else $error("more texts in flight than the two stages hold");

	a_found_term: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_found |-> out_end && out_byte == dfe_pkg::TERM_BYTE)
		else $error("found flag on a field byte");

endmodule

bind delimited_field_extractor_top dfe_checker u_dfe_checker (.*);

`default_nettype wire

// ===== dv/delimited_field_extractor_top_test.sv =====
// self-checking testbench of delimited_field_extractor_top: field selection, delimiter
// matching, terminal found flag; depends on dfe_pkg and the top level under rtl
`timescale 1ns / 1ps

typedef struct {
	logic [7:0] data;
	logic       term;
	logic       found;
} field_result_t;

// expected field bytes and terminals, kept in arrival order
class field_split_scoreboard;
	logic [31:0]   delim_bytes = dfe_pkg::DELIM_BYTES_RST;
	logic [2:0]    delim_len   = dfe_pkg::DELIM_LEN_RST;
	logic [15:0]   field_idx   = dfe_pkg::FIELD_IDX_RST;
	logic [7:0]    held[3];
	int            held_cnt;
	logic [15:0]   fields_done;
	bit            has_bytes;
	int            slots_left;
	int            errors;
	field_result_t expected_q[$];

	function new();
		errors = 0;
		clear_text();
	endfunction

	function void clear_text();
		foreach (held[k]) held[k] = 8'h00;
		held_cnt    = 0;
		fields_done = 16'h0000;
		has_bytes   = 1'b0;
	endfunction

	// length 0 acts as 1, lengths above four act as four
	function int eff_len();
		if (delim_len == 3'd0) return 1;
		if (delim_len > 3'd4) return 4;
		return int'(delim_len);
	endfunction

	function void set_reg(logic [dfe_pkg::CFG_IDX_W-1:0] addr, logic [31:0] data);
		case (addr)
			dfe_pkg::CFG_DELIM_BYTES: delim_bytes = data;
			dfe_pkg::CFG_DELIM_LEN:   delim_len   = data[2:0];
			dfe_pkg::CFG_FIELD_IDX:   field_idx   = data[15:0];
			default: ;
		endcase
	endfunction

	function void push_result(logic [7:0] b, logic term, logic found);
		field_result_t r;
		r.data  = b;
		r.term  = term;
		r.found = found;
		expected_q.insert(expected_q.size(), r);
	endfunction

	function void emit_byte(logic [7:0] b);
		if (fields_done == field_idx && slots_left > 0) begin
			push_result(b, 1'b0, 1'b0);
			slots_left--;
		end
		has_bytes = 1'b1;
	endfunction

	function void delimiter_hit();
		if (has_bytes && fields_done != 16'hFFFF) fields_done++;
		has_bytes = 1'b0;
	endfunction

	// scan held bytes plus the new one against the delimiter window
	function void note_byte(logic [7:0] b, bit last);
		logic [7:0] win[4];
		int         n;
		int         pos;
		int         len;
		int         rem;
		int         span;
		bit         hit;
		bit         hold;
		len = eff_len();
		n = held_cnt;
		for (int k = 0; k < n; k++) win[k] = held[k];
		win[n] = b;
		n++;
		slots_left = last ? dfe_pkg::RESULT_CAP - 1 : dfe_pkg::RESULT_CAP;
		pos = 0;
		hold = 1'b0;
		while (pos < n && !hold) begin
			rem  = n - pos;
			span = (rem < len) ? rem : len;
			hit  = 1'b1;
			for (int k = 0; k < span; k++)
				if (win[pos + k] != delim_bytes[8*k +: 8]) hit = 1'b0;
			if (hit && rem >= len) begin
				delimiter_hit();
				pos += len;
			end else if (hit) begin
				hold = 1'b1;
			end else begin
				emit_byte(win[pos]);
				pos++;
			end
		end
		held_cnt = n - pos;
		for (int k = 0; k < 3; k++) begin
			if (k < held_cnt) held[k] = win[pos + k];
			else held[k] = 8'h00;
		end
		if (last) begin
			for (int k = 0; k < held_cnt; k++) emit_byte(held[k]);
			push_result(dfe_pkg::TERM_BYTE, 1'b1,
				(fields_done > field_idx) || (fields_done == field_idx && has_bytes));
			clear_text();
		end
	endfunction

	function int outstanding();
		return expected_q.size();
	endfunction

	task report_mismatch(string what, logic [7:0] want, logic [7:0] got);
		$display("mismatch %s: expected %02h got %02h at %0t", what, want, got, $realtime);
		errors++;
	endtask

	task check_result(logic [7:0] b, logic term, logic found);
		field_result_t want;
		if (expected_q.size() == 0) begin
			report_mismatch("result with nothing expected, out_byte", 8'h00, b);
			return;
		end
		want = expected_q.pop_front();
		if (b !== want.data) report_mismatch("out_byte", want.data, b);
		if (term !== want.term) report_mismatch("out_end", {7'd0, want.term}, {7'd0, term});
		if (found !== want.found)
			report_mismatch("field_found", {7'd0, want.found}, {7'd0, found});
	endtask
endclass

module delimited_field_extractor_top_test;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 8;      // scan plus result register, with margin
	localparam int RANDOM_ITEMS  = 170;
	localparam logic [dfe_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;  // decodes to no register

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic [dfe_pkg::CFG_IDX_W-1:0]  cfg_addr  = dfe_pkg::CFG_DELIM_BYTES;
	logic [dfe_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	logic [7:0]                     in_byte   = 8'h00;
	logic                           in_last   = 1'b0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [7:0]                     out_byte;
	logic                           out_end;
	logic                           field_found;

	field_split_scoreboard sb;
	logic [7:0]            text_q[$];
	int                    burst_left = 0;
	int                    cycle_cnt  = 0;
	logic [12:0]           ready_pat  = 13'h0001;
	int                    pat_age    = 0;
	int                    rand_items;
	int                    cut;

	delimited_field_extractor_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.in_last     (in_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.out_end     (out_end),
		.field_found (field_found)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// runaway guard
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAIL delimited_field_extractor_top");
			$finish;
		end
	end

	// result side: check every transaction, then stall on a rotating pattern
	// the pattern always holds a one, so every stall ends
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_byte, out_end, field_found);
		if (pat_age == 0) begin
			if ($urandom_range(0, 3) == 0) ready_pat <= '1;   // stretch with no stalls
			else ready_pat <= 13'($urandom()) | 13'h0001;
			pat_age <= $urandom_range(20, 80);
		end else begin
			ready_pat <= {ready_pat[0], ready_pat[12:1]};
			pat_age   <= pat_age - 1;
		end
		out_ready <= ready_pat[0];
	end

	// one input transaction; bursts of random length with random gaps between them
	task automatic push_byte(input logic [7:0] b, input bit last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= last;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(b, last);
	endtask

	// send text_q[from..upto-1]; close marks the final byte as the end of the text
	task automatic send_span(input int from, input int upto, input bit close);
		for (int i = from; i < upto; i++) push_byte(text_q[i], close && (i == upto - 1));
	endtask

	// stop sending, let every expected result drain, then let the pipeline settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_cycle(input logic [dfe_pkg::CFG_IDX_W-1:0] addr,
			input logic [31:0] data);
		cfg_addr  <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		sb.set_reg(addr, data);
	endtask

	// all three registers in back-to-back writes, now and then a write to the spare index
	task automatic configure(input logic [31:0] dbytes, input logic [31:0] dlen_word,
			input logic [31:0] fidx_word);
		cfg_we <= 1'b1;
		cfg_cycle(dfe_pkg::CFG_DELIM_BYTES, dbytes);
		cfg_cycle(dfe_pkg::CFG_DELIM_LEN, dlen_word);
		cfg_cycle(dfe_pkg::CFG_FIELD_IDX, fidx_word);
		if ($urandom_range(0, 3) == 0) cfg_cycle(CFG_SPARE_IDX, $urandom());
		cfg_we <= 1'b0;
	endtask

	// random settings, extremes included; upper bits of the data word are junk
	task automatic random_config();
		logic [31:0] dbytes;
		logic [2:0]  dlen;
		logic [15:0] fidx;
		case ($urandom_range(0, 9))
			0: dlen = 3'd0;
			1: dlen = 3'($urandom_range(5, 7));
			default: dlen = 3'($urandom_range(1, 4));
		endcase
		case ($urandom_range(0, 7))
			0: dbytes = 32'h0000_0000;
			1: dbytes = 32'hFFFF_FFFF;
			2: dbytes = {4{8'($urandom_range(0, 255))}};   // repeated byte: overlap cases
			default: dbytes = $urandom();
		endcase
		case ($urandom_range(0, 9))
			0: fidx = 16'hFFFF;
			1: fidx = 16'($urandom_range(0, 65535));
			default: fidx = 16'($urandom_range(0, 3));
		endcase
		configure(dbytes, {29'($urandom()), dlen}, {16'($urandom()), fidx});
	endtask

	// text built mostly of whole delimiters, delimiter prefixes and delimiter bytes
	task automatic make_text(input int target, input bit noise);
		int         len;
		int         k;
		logic [7:0] dl[4];
		len = sb.eff_len();
		for (int i = 0; i < 4; i++) dl[i] = sb.delim_bytes[8*i +: 8];
		text_q.delete();
		while (text_q.size() < target) begin
			if (noise) begin
				text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2: for (int i = 0; i < len; i++) text_q.insert(text_q.size(), dl[i]);
					3: begin
						k = $urandom_range(1, len);
						for (int i = 0; i < k; i++) text_q.insert(text_q.size(), dl[i]);
					end
					4, 5: text_q.insert(text_q.size(), dl[$urandom_range(0, len - 1)]);
					default: text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
				endcase
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: newline delimiter, field zero; byte extremes inside the text
		text_q = {8'h61, 8'h00, 8'h0A, 8'hFF};
		send_span(0, text_q.size(), 1'b1);

		// empty fields around and between delimiters are not counted
		wait_idle();
		configure(32'h0000_000A, 32'd1, 32'd1);
		text_q = {8'h0A, 8'h78, 8'h0A, 8'h0A, 8'h79};
		send_span(0, text_q.size(), 1'b1);

		// selected field missing
		wait_idle();
		configure(32'h0000_000A, 32'd1, 32'd2);
		text_q = {8'h61, 8'h62};
		send_span(0, text_q.size(), 1'b1);

		// length zero behaves as one
		wait_idle();
		configure(32'h0000_002C, 32'd0, 32'd0);
		text_q = {8'h70, 8'h2C, 8'h71};
		send_span(0, text_q.size(), 1'b1);

		// length seven behaves as four; a leading delimiter is not counted as a field
		wait_idle();
		configure(32'h4443_4241, 32'd7, 32'd0);
		text_q = {8'h41, 8'h42, 8'h43, 8'h44, 8'h79};
		send_span(0, text_q.size(), 1'b1);

		// three held delimiter bytes then a mismatch on the last byte: result overflow
		text_q = {8'h41, 8'h42, 8'h43, 8'h58};
		send_span(0, text_q.size(), 1'b1);

		// delimiter changed while bytes are held; pause until everything has drained
		wait_idle();
		configure(32'h0043_4241, 32'd3, 32'd1);
		text_q = {8'h7A, 8'h41, 8'h42};
		send_span(0, text_q.size(), 1'b0);
		wait_idle();
		configure(32'h0000_0042, 32'd1, 32'd1);
		text_q = {8'h71};
		send_span(0, text_q.size(), 1'b1);

		// random texts under random settings, some split by a mid-text settings change
		rand_items = 0;
		while (rand_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				wait_idle();
				random_config();
			end
			make_text($urandom_range(1, 16), $urandom_range(0, 9) == 0);
			if (text_q.size() > 1 && $urandom_range(0, 7) == 0) begin
				cut = $urandom_range(1, text_q.size() - 1);
				send_span(0, cut, 1'b0);
				wait_idle();
				random_config();
				send_span(cut, text_q.size(), 1'b1);
			end else begin
				send_span(0, text_q.size(), 1'b1);
			end
			rand_items += text_q.size();
		end

		// drain, then let the pipeline settle to catch stray results
		wait_idle();
		if (sb.errors == 0) begin
			$display("PASS delimited_field_extractor_top");
		end else begin
			$display("FAIL delimited_field_extractor_top");
		end
		$finish;
	end
endmodule
